[design/slfs_pkg.sv]
// Shared types and constants for the sleep/listen frame scheduler.
package slfs_pkg;

   localparam int CfgWinBits = 10;
   localparam int CostBits   = 8;
   localparam int CountBits  = 16;
   localparam int EnergyBits = 32;
   localparam int CsrIdxBits = 3;

   // register indexes on the csr port
   localparam logic [CsrIdxBits-1:0] REG_DOUBLING_MODE = 3'd0;
   localparam logic [CsrIdxBits-1:0] REG_INITIAL_SLEEP = 3'd1;
   localparam logic [CsrIdxBits-1:0] REG_MAX_SLEEP     = 3'd2;
   localparam logic [CsrIdxBits-1:0] REG_LISTEN_WINDOW = 3'd3;
   localparam logic [CsrIdxBits-1:0] REG_START_OFFSET  = 3'd4;
   localparam logic [CsrIdxBits-1:0] REG_SLEEP_COST    = 3'd5;
   localparam logic [CsrIdxBits-1:0] REG_LISTEN_COST   = 3'd6;

   typedef struct packed {
      logic                  doubling_mode;
      logic [CfgWinBits-1:0] initial_sleep;
      logic [CfgWinBits-1:0] max_sleep;
      logic [CfgWinBits-1:0] listen_window;
      logic [CfgWinBits-1:0] start_offset;
      logic [CostBits-1:0]   sleep_cost;
      logic [CostBits-1:0]   listen_cost;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      doubling_mode: 1'b0,
      initial_sleep: 10'd1,
      max_sleep:     10'd16,
      listen_window: 10'd1,
      start_offset:  10'd0,
      sleep_cost:    8'd1,
      listen_cost:   8'd10
   };

   typedef struct packed {
      logic [CountBits-1:0]  sleep_total;
      logic [CountBits-1:0]  listen_total;
      logic [EnergyBits-1:0] energy_total;
   } totals_type;

endpackage

[design/slfs_sched.sv]
// Sleep/listen window sequencer: decides the kind of each frame.
module slfs_sched #(
   parameter int WINDOW_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  slfs_pkg::cfg_type cfg,
   input  logic              reload,
   input  logic              step,
   input  logic              restart,
   output logic              frame_listen
);

   localparam int WB     = WINDOW_BITS;
   localparam int ExtBits = (WB > slfs_pkg::CfgWinBits) ? WB : slfs_pkg::CfgWinBits;

   logic [WB-1:0] sleep_left_ff, sleep_left_in;
   logic [WB-1:0] listen_left_ff, listen_left_in;
   logic [WB-1:0] window_ff, window_in;
   logic [WB-1:0] offset_left_ff, offset_left_in;

   logic [ExtBits-1:0] init_x, max_x, listen_x, offset_x;
   logic [WB-1:0]      init_w, top_w, listen_w, offset_w, first_w;
   logic [WB:0]        doubled;

   // window registers taken modulo 2^WINDOW_BITS
   always_comb begin
      init_x   = ExtBits'(cfg.initial_sleep);
      max_x    = ExtBits'(cfg.max_sleep);
      listen_x = ExtBits'(cfg.listen_window);
      offset_x = ExtBits'(cfg.start_offset);
      init_w   = init_x[WB-1:0];
      top_w    = max_x[WB-1:0];
      listen_w = listen_x[WB-1:0];
      offset_w = offset_x[WB-1:0];
      first_w  = (cfg.doubling_mode && (init_w > top_w)) ? top_w : init_w;
   end

   always_comb begin
      sleep_left_in  = sleep_left_ff;
      listen_left_in = listen_left_ff;
      window_in      = window_ff;
      offset_left_in = offset_left_ff;
      doubled        = '0;
      frame_listen   = 1'b1;
      if (restart) begin
         sleep_left_in  = first_w;
         listen_left_in = listen_w;
         window_in      = first_w;
         offset_left_in = offset_w;
      end
      if (offset_left_in != '0) begin
         offset_left_in = offset_left_in - 1'b1;
      end else begin
         if ((sleep_left_in == '0) && (listen_left_in == '0)) begin
            doubled = {window_in, 1'b0};
            if (cfg.doubling_mode && (window_in < top_w)) begin
               window_in = (doubled > {1'b0, top_w}) ? top_w : doubled[WB-1:0];
            end
            sleep_left_in  = window_in;
            listen_left_in = listen_w;
         end
         if (sleep_left_in != '0) begin
            sleep_left_in = sleep_left_in - 1'b1;
            frame_listen  = 1'b0;
         end else if (listen_left_in != '0) begin
            listen_left_in = listen_left_in - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || reload) begin
         sleep_left_ff  <= first_w;
         listen_left_ff <= listen_w;
         window_ff      <= first_w;
         offset_left_ff <= offset_w;
      end else if (step) begin
         sleep_left_ff  <= sleep_left_in;
         listen_left_ff <= listen_left_in;
         window_ff      <= window_in;
         offset_left_ff <= offset_left_in;
      end
   end

endmodule

[design/slfs_tally.sv]
// Saturating frame counters and energy accumulator.
module slfs_tally (
   input  logic                 clock,
   input  logic                 reset,
   input  slfs_pkg::cfg_type    cfg,
   input  logic                 step,
   input  logic                 restart,
   input  logic                 frame_listen,
   output slfs_pkg::totals_type totals_next
);

   localparam int EB = slfs_pkg::EnergyBits;
   localparam int CB = slfs_pkg::CountBits;

   slfs_pkg::totals_type tot_ff;
   slfs_pkg::totals_type base;
   logic [slfs_pkg::CostBits-1:0] cost;
   logic [EB:0]                   sum;

   always_comb begin
      base        = restart ? '0 : tot_ff;
      totals_next = base;
      if (frame_listen) begin
         cost = cfg.listen_cost;
         if (base.listen_total != {CB{1'b1}}) begin
            totals_next.listen_total = base.listen_total + 1'b1;
         end
      end else begin
         cost = cfg.sleep_cost;
         if (base.sleep_total != {CB{1'b1}}) begin
            totals_next.sleep_total = base.sleep_total + 1'b1;
         end
      end
      sum = {1'b0, base.energy_total} + (EB + 1)'(cost);
      totals_next.energy_total = sum[EB] ? {EB{1'b1}} : sum[EB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff <= '0;
      end else if (step) begin
         tot_ff <= totals_next;
      end
   end

endmodule

[design/sleep_listen_frame_scheduler.sv]
// Top level of the sleep/listen frame scheduler.
// Each request transfer is one frame tick; the block answers with one response
// transfer saying whether the station sleeps (0) or listens (1) in that frame,
// plus saturating totals of sleep frames, listen frames and energy units.
// The schedule listens for start_offset frames, then alternates a sleep window
// and a listen window; with doubling_mode set each sleep window is twice the
// previous one up to max_sleep (an initial window above max_sleep is clamped),
// otherwise the windows repeat unchanged. A period with both windows empty
// yields a listen frame. restart=1 restarts the schedule and clears the totals
// before the frame is counted. Writing any schedule register (indexes 0..4)
// reloads the schedule but keeps the totals; cost writes apply from the next
// frame; unknown indexes are dropped. Write csr only while idle.
// Rate: one frame per clock cycle sustained while rsp_tready stays high. A frame
// is captured in the input register, processed in one pass of the window
// sequencer and counters, and lands in the response register. The response
// register lets a new frame in while the last result waits; back-pressure
// stalls only when both registers are full.
module sleep_listen_frame_scheduler #(
   parameter int WINDOW_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request: frame tick
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // response: frame decision and totals
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [0] frame_listen, [16:1] sleep_total,
                                    // [32:17] listen_total, [64:33] energy_total,
                                    // [71:65] zero
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [slfs_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [slfs_pkg::CfgWinBits-1:0] csr_data
);

   slfs_pkg::cfg_type    cfg_ff, cfg_in;
   slfs_pkg::totals_type totals_next;
   slfs_pkg::totals_type rsp_totals_ff;

   logic in_valid_ff, in_valid_in;
   logic in_restart_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_listen_ff;
   logic advance;
   logic csr_xfer;
   logic reload;
   logic frame_listen;

   // config registers; cfg_in is the value after this cycle's write
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      reload = 1'b0;
      if (reset) begin
         cfg_in = slfs_pkg::CFG_RESET;
      end else if (csr_xfer) begin
         case (csr_index)
            slfs_pkg::REG_DOUBLING_MODE: begin
               cfg_in.doubling_mode = csr_data[0];
               reload = 1'b1;
            end
            slfs_pkg::REG_INITIAL_SLEEP: begin
               cfg_in.initial_sleep = csr_data;
               reload = 1'b1;
            end
            slfs_pkg::REG_MAX_SLEEP: begin
               cfg_in.max_sleep = csr_data;
               reload = 1'b1;
            end
            slfs_pkg::REG_LISTEN_WINDOW: begin
               cfg_in.listen_window = csr_data;
               reload = 1'b1;
            end
            slfs_pkg::REG_START_OFFSET: begin
               cfg_in.start_offset = csr_data;
               reload = 1'b1;
            end
            slfs_pkg::REG_SLEEP_COST: begin
               cfg_in.sleep_cost = csr_data[slfs_pkg::CostBits-1:0];
            end
            slfs_pkg::REG_LISTEN_COST: begin
               cfg_in.listen_cost = csr_data[slfs_pkg::CostBits-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   // input register -> one pass -> response register
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_restart_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_listen_ff <= frame_listen;
         rsp_totals_ff <= totals_next;
      end
   end

   slfs_sched #(
      .WINDOW_BITS(WINDOW_BITS)
   ) u_sched (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_in),
      .reload      (reload),
      .step        (advance),
      .restart     (in_restart_ff),
      .frame_listen(frame_listen)
   );

   slfs_tally u_tally (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_in),
      .step        (advance),
      .restart     (in_restart_ff),
      .frame_listen(frame_listen),
      .totals_next (totals_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_totals_ff.energy_total, rsp_totals_ff.listen_total,
                        rsp_totals_ff.sleep_total, rsp_listen_ff};

`ifndef SYNTH
   // a processed frame always shows up as a response next cycle
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed frame did not reach response register");

   // a restarted frame counts exactly one frame
   a_restart_one: assert property (@(posedge clock) disable iff (reset)
      (advance && in_restart_ff) |=>
         ((rsp_tdata[16:1] == 16'd0 && rsp_tdata[32:17] == 16'd1) ||
          (rsp_tdata[16:1] == 16'd1 && rsp_tdata[32:17] == 16'd0)))
      else $error("restart did not clear totals");

   // on a restarted frame, the frame kind matches which counter moved
   a_kind_total: assert property (@(posedge clock) disable iff (reset)
      (advance && in_restart_ff) |=> (rsp_tdata[0] == (rsp_tdata[32:17] == 16'd1)))
      else $error("frame kind disagrees with counters");

   // input register never overwritten while holding an unprocessed frame
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready && in_valid_ff && !advance))
      else $error("input register overrun");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sleep_listen_frame_scheduler: directed and random frame ticks.
module tb_top;

   // index with no register behind it; writes to it must be dropped
   localparam logic [slfs_pkg::CsrIdxBits-1:0] REG_UNUSED = 3'd7;

   // one frame decision plus the running totals, as the block reports it
   typedef struct packed {
      logic                            listen;
      logic [slfs_pkg::CountBits-1:0]  sleep_total;
      logic [slfs_pkg::CountBits-1:0]  listen_total;
      logic [slfs_pkg::EnergyBits-1:0] energy_total;
   } frame_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // [0] restart, [7:1] zero
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [71:0]                     rsp_tdata;   // [0] frame_listen, [16:1] sleep_total,
                                                 // [32:17] listen_total, [64:33] energy_total
   logic                            csr_valid;
   logic                            csr_ready;
   logic [slfs_pkg::CsrIdxBits-1:0] csr_index;
   logic [slfs_pkg::CfgWinBits-1:0] csr_data;

   // shadow of the register file and of the schedule state
   slfs_pkg::cfg_type               sched_cfg;
   logic [slfs_pkg::CfgWinBits-1:0] sleep_left;
   logic [slfs_pkg::CfgWinBits-1:0] listen_left;
   logic [slfs_pkg::CfgWinBits-1:0] cur_window;
   logic [slfs_pkg::CfgWinBits-1:0] offset_left;
   logic [slfs_pkg::CountBits-1:0]  sleep_count;
   logic [slfs_pkg::CountBits-1:0]  listen_count;
   logic [slfs_pkg::EnergyBits-1:0] energy_sum;

   frame_result_type pending_frames[$];   // decisions predicted but not yet seen
   int               error_count;
   bit               idle_on;             // random gaps and stalls allowed

   sleep_listen_frame_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Schedule predictor
   // ---------------------------------------------------------------

   // back to frame zero of the schedule; totals untouched
   function automatic void reload_schedule();
      logic [slfs_pkg::CfgWinBits-1:0] first;
      first = sched_cfg.initial_sleep;
      // only the doubling class clamps the first window to the ceiling
      if (sched_cfg.doubling_mode && first > sched_cfg.max_sleep)
         first = sched_cfg.max_sleep;
      cur_window  = first;
      sleep_left  = first;
      listen_left = sched_cfg.listen_window;
      offset_left = sched_cfg.start_offset;
   endfunction

   // a new sleep/listen period; doubling saturates at max_sleep, zero stays zero
   function automatic void open_period();
      logic [slfs_pkg::CfgWinBits:0] doubled;
      if (sched_cfg.doubling_mode && cur_window < sched_cfg.max_sleep) begin
         doubled = {cur_window, 1'b0};
         if (doubled > {1'b0, sched_cfg.max_sleep})
            doubled = {1'b0, sched_cfg.max_sleep};
         cur_window = doubled[slfs_pkg::CfgWinBits-1:0];
      end
      sleep_left  = cur_window;
      listen_left = sched_cfg.listen_window;
   endfunction

   function automatic void apply_reg_write(input logic [slfs_pkg::CsrIdxBits-1:0] idx,
                                           input logic [slfs_pkg::CfgWinBits-1:0] value);
      case (idx)
         slfs_pkg::REG_DOUBLING_MODE: begin
            sched_cfg.doubling_mode = value[0];
            reload_schedule();
         end
         slfs_pkg::REG_INITIAL_SLEEP: begin
            sched_cfg.initial_sleep = value;
            reload_schedule();
         end
         slfs_pkg::REG_MAX_SLEEP: begin
            sched_cfg.max_sleep = value;
            reload_schedule();
         end
         slfs_pkg::REG_LISTEN_WINDOW: begin
            sched_cfg.listen_window = value;
            reload_schedule();
         end
         slfs_pkg::REG_START_OFFSET: begin
            sched_cfg.start_offset = value;
            reload_schedule();
         end
         slfs_pkg::REG_SLEEP_COST:
            sched_cfg.sleep_cost = value[slfs_pkg::CostBits-1:0];
         slfs_pkg::REG_LISTEN_COST:
            sched_cfg.listen_cost = value[slfs_pkg::CostBits-1:0];
         default: ;
      endcase
   endfunction

   // advance one frame tick and return the decision with updated totals
   function automatic frame_result_type next_frame(input logic restart);
      frame_result_type                res;
      logic [slfs_pkg::EnergyBits-1:0] cost;
      logic                            is_listen;
      if (restart) begin
         sleep_count  = '0;
         listen_count = '0;
         energy_sum   = '0;
         reload_schedule();
      end
      if (offset_left != 0) begin
         offset_left--;
         is_listen = 1'b1;
      end else begin
         if (sleep_left == 0 && listen_left == 0)
            open_period();
         if (sleep_left != 0) begin
            sleep_left--;
            is_listen = 1'b0;
         end else if (listen_left != 0) begin
            listen_left--;
            is_listen = 1'b1;
         end else begin
            is_listen = 1'b1;   // both windows empty: listen
         end
      end
      if (is_listen) begin
         if (listen_count != '1)
            listen_count++;
         cost = slfs_pkg::EnergyBits'(sched_cfg.listen_cost);
      end else begin
         if (sleep_count != '1)
            sleep_count++;
         cost = slfs_pkg::EnergyBits'(sched_cfg.sleep_cost);
      end
      // saturating add: ~cost is the headroom left below all ones
      if (energy_sum > ~cost)
         energy_sum = '1;
      else
         energy_sum = energy_sum + cost;
      res.listen       = is_listen;
      res.sleep_total  = sleep_count;
      res.listen_total = listen_count;
      res.energy_total = energy_sum;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what,
                                  input logic [slfs_pkg::EnergyBits-1:0] got,
                                  input logic [slfs_pkg::EnergyBits-1:0] want);
      error_count++;
      if (error_count <= 40)
         $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Everything is sampled at the rising edge: register writes and frame
   // transfers update the predictor, result transfers are checked in order.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            apply_reg_write(csr_index, csr_data);
         if (req_tvalid && req_tready)
            pending_frames.push_back(next_frame(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               report_mismatch("result with no frame pending", rsp_tdata[31:0], '0);
            end else begin
               want = pending_frames.pop_front();
               if (rsp_tdata[0] !== want.listen)
                  report_mismatch("frame_listen", rsp_tdata[0], want.listen);
               if (rsp_tdata[16:1] !== want.sleep_total)
                  report_mismatch("sleep_total", rsp_tdata[16:1], want.sleep_total);
               if (rsp_tdata[32:17] !== want.listen_total)
                  report_mismatch("listen_total", rsp_tdata[32:17], want.listen_total);
               if (rsp_tdata[64:33] !== want.energy_total)
                  report_mismatch("energy_total", rsp_tdata[64:33], want.energy_total);
               if (rsp_tdata[71:65] !== '0)
                  report_mismatch("tdata padding", rsp_tdata[71:65], '0);
            end
         end
      end
   end

   // Receiver: random stall bursts while idling is on.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Drivers: all called and returning at a falling edge
   // ---------------------------------------------------------------

   task automatic send_frame(input logic restart);
      if (idle_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(input logic [slfs_pkg::CsrIdxBits-1:0] idx,
                            input logic [slfs_pkg::CfgWinBits-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // sender holds off until every predicted frame has been seen
   task automatic wait_results_drained();
      while (pending_frames.size() != 0)
         @(negedge clock);
   endtask

   task automatic send_frames(input int count);
      for (int i = 0; i < count; i++)
         send_frame(1'b0);
   endtask

   // window lengths mostly short so periods actually turn over
   function automatic logic [slfs_pkg::CfgWinBits-1:0] pick_window();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return slfs_pkg::CfgWinBits'($urandom_range(0, 6));
         7:       return slfs_pkg::CfgWinBits'($urandom_range(0, 20));
         8:       return $urandom_range(0, 1) ? '1 : '0;
         default: return slfs_pkg::CfgWinBits'($urandom);
      endcase
   endfunction

   // costs: full csr word, upper bits must be ignored; extremes now and then
   function automatic logic [slfs_pkg::CfgWinBits-1:0] pick_cost();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return slfs_pkg::CfgWinBits'(10'h0FF);
         default: return slfs_pkg::CfgWinBits'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // reset values: fixed class, one sleep frame then one listen frame
   task automatic test_default_schedule();
      send_frames(3);
      send_frame(1'b1);   // restart clears totals before this frame
   endtask

   // doubling class: windows 1, 2, then 3 (doubled 4 capped by max_sleep)
   task automatic test_doubling_windows();
      wait_results_drained();
      write_reg(slfs_pkg::REG_DOUBLING_MODE, 10'd1);
      write_reg(slfs_pkg::REG_INITIAL_SLEEP, 10'd1);
      write_reg(slfs_pkg::REG_MAX_SLEEP, 10'd3);
      write_reg(slfs_pkg::REG_LISTEN_WINDOW, 10'd0);
      send_frames(6);
   endtask

   // first window above the ceiling gets clamped in the doubling class
   task automatic test_initial_clamp();
      wait_results_drained();
      write_reg(slfs_pkg::REG_INITIAL_SLEEP, 10'd20);
      write_reg(slfs_pkg::REG_MAX_SLEEP, 10'd2);
      write_reg(slfs_pkg::REG_LISTEN_WINDOW, 10'd1);
      send_frames(3);
   endtask

   // both windows empty listens; a zero window stays zero when doubled
   task automatic test_empty_windows();
      wait_results_drained();
      write_reg(slfs_pkg::REG_DOUBLING_MODE, 10'd0);
      write_reg(slfs_pkg::REG_INITIAL_SLEEP, 10'd0);
      write_reg(slfs_pkg::REG_LISTEN_WINDOW, 10'd0);
      send_frames(2);
      wait_results_drained();
      write_reg(slfs_pkg::REG_DOUBLING_MODE, 10'd1);
      write_reg(slfs_pkg::REG_LISTEN_WINDOW, 10'd1);
      send_frames(2);
   endtask

   // forced listening before the first sleep window, doubling class too
   task automatic test_start_offset();
      wait_results_drained();
      write_reg(slfs_pkg::REG_INITIAL_SLEEP, 10'd1);
      write_reg(slfs_pkg::REG_MAX_SLEEP, 10'd4);
      write_reg(slfs_pkg::REG_START_OFFSET, 10'd2);
      send_frames(5);
   endtask

   // all-ones windows and costs at both ends; the unused index is dropped
   task automatic test_register_extremes();
      wait_results_drained();
      write_reg(slfs_pkg::REG_INITIAL_SLEEP, '1);
      write_reg(slfs_pkg::REG_MAX_SLEEP, '1);
      write_reg(slfs_pkg::REG_LISTEN_WINDOW, '1);
      write_reg(slfs_pkg::REG_START_OFFSET, '1);
      write_reg(slfs_pkg::REG_SLEEP_COST, 10'd255);
      write_reg(slfs_pkg::REG_LISTEN_COST, 10'd0);
      send_frames(2);
      wait_results_drained();
      write_reg(slfs_pkg::REG_START_OFFSET, 10'd0);
      write_reg(REG_UNUSED, '1);
      send_frames(2);
   endtask

   // Random phases: rewrite every register in a randomly rotated order, then a run of
   // frames with occasional restarts. The final phase runs without idling.
   task automatic test_random_schedules();
      logic [slfs_pkg::CsrIdxBits-1:0] reg_order[7] = '{
         slfs_pkg::REG_DOUBLING_MODE, slfs_pkg::REG_INITIAL_SLEEP,
         slfs_pkg::REG_MAX_SLEEP, slfs_pkg::REG_LISTEN_WINDOW,
         slfs_pkg::REG_START_OFFSET, slfs_pkg::REG_SLEEP_COST,
         slfs_pkg::REG_LISTEN_COST};
      logic [slfs_pkg::CsrIdxBits-1:0] idx;
      logic [slfs_pkg::CfgWinBits-1:0] value;
      int                              budget;
      int                              run_len;
      int                              rot;
      bit                              tail;
      budget = 1500;
      while (budget > 0) begin
         tail = (budget <= 200);
         wait_results_drained();
         repeat (3) @(negedge clock);
         idle_on = tail ? 1'b0 : ($urandom_range(0, 3) != 0);
         rot = $urandom_range(0, 6);
         for (int k = 0; k < 7; k++) begin
            idx = reg_order[(rot + k) % 7];
            if (idx == slfs_pkg::REG_SLEEP_COST || idx == slfs_pkg::REG_LISTEN_COST)
               value = pick_cost();
            else if (idx == slfs_pkg::REG_DOUBLING_MODE)
               value = slfs_pkg::CfgWinBits'($urandom);
            else
               value = pick_window();
            write_reg(idx, value);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, slfs_pkg::CfgWinBits'($urandom));
         run_len = tail ? budget : $urandom_range(20, 150);
         if (run_len > budget)
            run_len = budget;
         for (int i = 0; i < run_len; i++) begin
            // mid-run pause until the pipeline is empty
            if (i == run_len / 2)
               wait_results_drained();
            send_frame($urandom_range(0, 24) == 0);
         end
         budget -= run_len;
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = slfs_pkg::REG_DOUBLING_MODE;
      csr_data     = '0;
      idle_on      = 1'b1;
      error_count  = 0;
      sched_cfg    = slfs_pkg::CFG_RESET;
      sleep_count  = '0;
      listen_count = '0;
      energy_sum   = '0;
      reload_schedule();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_schedule();
      test_doubling_windows();
      test_initial_clamp();
      test_empty_windows();
      test_start_offset();
      test_register_extremes();
      test_random_schedules();

      wait_results_drained();
      repeat (10) @(posedge clock);
      if (pending_frames.size() != 0)
         report_mismatch("frames left without a result", pending_frames.size(), '0);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
